// ----- rtl/slt_pkg.sv -----
// Shared types, token codes and character helpers for the script lexer.
// Used by slt_scan and script_lexer_tokenizer; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

  // Token kind codes.
  localparam logic [5:0] TK_EOF       = 6'd0;
  localparam logic [5:0] TK_ERROR     = 6'd1;
  localparam logic [5:0] TK_IDENT     = 6'd2;
  localparam logic [5:0] TK_NUMBER    = 6'd3;
  localparam logic [5:0] TK_STRING    = 6'd4;
  localparam logic [5:0] TK_PLUS      = 6'd5;
  localparam logic [5:0] TK_MINUS     = 6'd6;
  localparam logic [5:0] TK_MUL       = 6'd7;
  localparam logic [5:0] TK_DIV       = 6'd8;
  localparam logic [5:0] TK_MOD       = 6'd9;
  localparam logic [5:0] TK_ASSIGN    = 6'd10;
  localparam logic [5:0] TK_EQUALS    = 6'd11;
  localparam logic [5:0] TK_NE        = 6'd12;
  localparam logic [5:0] TK_LESS      = 6'd13;
  localparam logic [5:0] TK_GREATER   = 6'd14;
  localparam logic [5:0] TK_LE        = 6'd15;
  localparam logic [5:0] TK_GE        = 6'd16;
  localparam logic [5:0] TK_BANG      = 6'd17;
  localparam logic [5:0] TK_AND       = 6'd18;
  localparam logic [5:0] TK_OR        = 6'd19;
  localparam logic [5:0] TK_LPAREN    = 6'd20;
  localparam logic [5:0] TK_RPAREN    = 6'd21;
  localparam logic [5:0] TK_LBRACE    = 6'd22;
  localparam logic [5:0] TK_RBRACE    = 6'd23;
  localparam logic [5:0] TK_LBRACKET  = 6'd24;
  localparam logic [5:0] TK_RBRACKET  = 6'd25;
  localparam logic [5:0] TK_COMMA     = 6'd26;
  localparam logic [5:0] TK_SEMI      = 6'd27;
  localparam logic [5:0] TK_DOT       = 6'd28;

  // Error kind codes.
  localparam logic [2:0] ER_NONE      = 3'd0;
  localparam logic [2:0] ER_UNEXPECT  = 3'd1;
  localparam logic [2:0] ER_LONE_AMP  = 3'd2;
  localparam logic [2:0] ER_LONE_BAR  = 3'd3;
  localparam logic [2:0] ER_UNTERM    = 3'd4;

  // Keyword buffer holds this many characters.
  localparam int KW_CHARS = 7;
  localparam int KW_COUNT = 12;

  // Keyword text is right aligned, first character most significant.
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "func", "print", "println", "loop", "if", "else",
    "return", "var", "true", "false", "null", "break"
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd4, 3'd5, 3'd7, 3'd4, 3'd2, 3'd4, 3'd6, 3'd3, 3'd4, 3'd5, 3'd4, 3'd5
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40
  };

  // Result queue between the scanner and the output port.
  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [5:0] kind;
    logic [2:0] err;
    logic       last;
  } tag_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  // Kind of a one-character token, or TK_ERROR when the byte is not one.
  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      "[":     k = TK_LBRACKET;
      "]":     k = TK_RBRACKET;
      ";":     k = TK_SEMI;
      ",":     k = TK_COMMA;
      ".":     k = TK_DOT;
      "-":     k = TK_MINUS;
      "+":     k = TK_PLUS;
      "*":     k = TK_MUL;
      "%":     k = TK_MOD;
      default: k = TK_ERROR;
    endcase
    return k;
  endfunction

  // chars holds buffer entry 0 in its top byte. Only the first len entries count.
  function automatic logic [5:0] keyword_kind(input logic [8*KW_CHARS-1:0] chars,
                                              input logic [2:0] len);
    logic [5:0]              kind;
    logic [8*KW_CHARS-1:0]   head;
    head = chars >> {3'd7 - len, 3'b000};
    kind = TK_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (KW_LEN[i] == len && head == KW_TEXT[i]) begin
        kind = KW_KIND[i];
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/slt_scan.sv -----
// Scanner core: lexer state, position counters and keyword buffer.
// Turns one source item into up to three token records; uses slt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slt_scan
  import slt_pkg::*;
#(
  parameter int POSITION_BITS = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     go,
  input  wire logic [7:0]               c,
  input  wire logic                     last_item,
  output logic [1:0]                    n,
  output tag_t                          tag  [3],
  output logic [POSITION_BITS-1:0]      line [3],
  output logic [POSITION_BITS-1:0]      col  [3],
  output logic [OFFSET_BITS-1:0]        off  [3],
  output logic [POSITION_BITS-1:0]      len  [3]
);

  localparam int P = POSITION_BITS;
  localparam int O = OFFSET_BITS;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUMBER, M_NUMDOT, M_FRACTION,
    M_STRING, M_BANG, M_EQ, M_LT, M_GT, M_AMP, M_BAR, M_DONE
  } mode_t;

  mode_t          mode, mode_next;
  logic [P-1:0]   line_cnt, line_cnt_next;
  logic [P-1:0]   col_cnt, col_cnt_next;
  logic [O-1:0]   offset, offset_next;
  logic [P-1:0]   tline, tline_next;
  logic [P-1:0]   tcol, tcol_next;
  logic [O-1:0]   toff, toff_next;
  logic [P-1:0]   tlen, tlen_next;
  logic [7:0]     kw [KW_CHARS];

  logic           kw_we;
  logic [2:0]     kw_wa;
  logic           used;
  logic           eqnext;
  logic           a_en, b_en, c_en;
  logic [5:0]     a_kind, c_kind;
  logic [2:0]     a_err, c_err;
  logic [P-1:0]   a_len, c_len;
  logic [P-1:0]   b_col;
  logic [5:0]     lone;
  logic [5:0]     pair;

  function automatic logic [P-1:0] sat_add(input logic [P-1:0] x, input logic [P-1:0] y);
    logic [P:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[P] ? {P{1'b1}} : s[P-1:0];
  endfunction

  assign eqnext = !last_item && c == "=";
  assign b_col  = sat_add(tcol, tlen);

  // One- and two-character kinds of the pending comparison operator.
  always_comb begin
    unique case (mode)
      M_BANG:  begin lone = TK_BANG;    pair = TK_NE;     end
      M_EQ:    begin lone = TK_ASSIGN;  pair = TK_EQUALS; end
      M_LT:    begin lone = TK_LESS;    pair = TK_LE;     end
      default: begin lone = TK_GREATER; pair = TK_GE;     end
    endcase
  end

  always_comb begin
    mode_next     = mode;
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    offset_next   = offset;
    tline_next    = tline;
    tcol_next     = tcol;
    toff_next     = toff;
    tlen_next     = tlen;
    kw_we         = 1'b0;
    kw_wa         = tlen[2:0];
    used          = 1'b0;
    a_en          = 1'b0;
    a_kind        = TK_ERROR;
    a_err         = ER_NONE;
    a_len         = tlen;
    b_en          = 1'b0;
    c_en          = 1'b0;
    c_kind        = TK_EOF;
    c_err         = ER_NONE;
    c_len         = '0;

    if (mode == M_DONE) begin
      // After end of source every item only repeats the EOF token.
      c_en = 1'b1;
    end else begin
      unique case (mode)
        M_SLASH: begin
          if (!last_item && c == "/") begin
            mode_next = M_COMMENT;
            used      = 1'b1;
          end else begin
            a_en      = 1'b1;
            a_kind    = TK_DIV;
            mode_next = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (last_item || c == 8'h0A) begin
            mode_next = M_IDLE;
          end else begin
            used = 1'b1;
          end
        end
        M_IDENT: begin
          if (!last_item && is_ident(c)) begin
            kw_we     = tlen < P'(KW_CHARS);
            tlen_next = sat_add(tlen, P'(1));
            used      = 1'b1;
          end else begin
            a_en      = 1'b1;
            a_kind    = (tlen <= P'(KW_CHARS)) ?
                        keyword_kind({kw[0], kw[1], kw[2], kw[3], kw[4], kw[5], kw[6]},
                                     tlen[2:0]) : TK_IDENT;
            mode_next = M_IDLE;
          end
        end
        M_NUMBER, M_FRACTION: begin
          if (!last_item && is_digit(c)) begin
            tlen_next = sat_add(tlen, P'(1));
            used      = 1'b1;
          end else if (!last_item && c == "." && mode == M_NUMBER) begin
            mode_next = M_NUMDOT;
            used      = 1'b1;
          end else begin
            a_en      = 1'b1;
            a_kind    = TK_NUMBER;
            mode_next = M_IDLE;
          end
        end
        M_NUMDOT: begin
          if (!last_item && is_digit(c)) begin
            tlen_next = sat_add(tlen, P'(2));
            mode_next = M_FRACTION;
            used      = 1'b1;
          end else begin
            // The held dot becomes its own token right after the number.
            a_en      = 1'b1;
            a_kind    = TK_NUMBER;
            b_en      = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_STRING: begin
          if (last_item) begin
            a_en      = 1'b1;
            a_kind    = TK_ERROR;
            a_err     = ER_UNTERM;
            mode_next = M_IDLE;
          end else begin
            tlen_next = sat_add(tlen, P'(1));
            a_len     = tlen_next;
            used      = 1'b1;
            if (c == 8'h22) begin
              a_en      = 1'b1;
              a_kind    = TK_STRING;
              mode_next = M_IDLE;
            end
          end
        end
        M_BANG, M_EQ, M_LT, M_GT: begin
          a_en      = 1'b1;
          mode_next = M_IDLE;
          if (eqnext) begin
            a_kind    = pair;
            a_len     = P'(2);
            tlen_next = P'(2);
            used      = 1'b1;
          end else begin
            a_kind = lone;
          end
        end
        M_AMP, M_BAR: begin
          a_en      = 1'b1;
          mode_next = M_IDLE;
          if (!last_item && c == ((mode == M_AMP) ? "&" : "|")) begin
            a_kind    = (mode == M_AMP) ? TK_AND : TK_OR;
            a_len     = P'(2);
            tlen_next = P'(2);
            used      = 1'b1;
          end else begin
            a_kind = TK_ERROR;
            a_err  = (mode == M_AMP) ? ER_LONE_AMP : ER_LONE_BAR;
          end
        end
        M_IDLE, M_DONE: begin
          mode_next = M_IDLE;
        end
      endcase

      if (last_item) begin
        c_en      = 1'b1;
        mode_next = M_DONE;
      end else begin
        if (!used && !(c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A)) begin
          tline_next = line_cnt;
          tcol_next  = col_cnt;
          toff_next  = offset;
          tlen_next  = P'(1);
          unique case (c)
            "/":     mode_next = M_SLASH;
            8'h22:   mode_next = M_STRING;
            "!":     mode_next = M_BANG;
            "=":     mode_next = M_EQ;
            "<":     mode_next = M_LT;
            ">":     mode_next = M_GT;
            "&":     mode_next = M_AMP;
            "|":     mode_next = M_BAR;
            default: mode_next = M_IDLE;
          endcase
          if (is_alpha(c) || c == "_") begin
            mode_next = M_IDENT;
            kw_we     = 1'b1;
            kw_wa     = 3'd0;
          end else if (is_digit(c)) begin
            mode_next = M_NUMBER;
          end else if (mode_next == M_IDLE) begin
            c_en   = 1'b1;
            c_kind = single_kind(c);
            c_err  = (single_kind(c) == TK_ERROR) ? ER_UNEXPECT : ER_NONE;
            c_len  = P'(1);
          end
        end
        offset_next = offset + O'(1);
        if (c == 8'h0A) begin
          line_cnt_next = sat_add(line_cnt, P'(1));
          col_cnt_next  = P'(1);
        end else begin
          col_cnt_next = sat_add(col_cnt, P'(1));
        end
      end
    end
  end

  // Pack the present records in order: pending token, held dot, then the
  // token or EOF that the current byte produces.
  always_comb begin
    n = 2'(a_en) + 2'(b_en) + 2'(c_en);

    tag[2]  = '{kind: c_kind, err: c_err, last: 1'b0};
    line[2] = line_cnt;
    col[2]  = col_cnt;
    off[2]  = offset;
    len[2]  = c_len;

    if (b_en) begin
      tag[1]  = '{kind: TK_DOT, err: ER_NONE, last: 1'b0};
      line[1] = tline;
      col[1]  = b_col;
      off[1]  = offset - O'(1);
      len[1]  = P'(1);
    end else begin
      tag[1]  = tag[2];
      line[1] = line[2];
      col[1]  = col[2];
      off[1]  = off[2];
      len[1]  = len[2];
    end

    if (a_en) begin
      tag[0]  = '{kind: a_kind, err: a_err, last: 1'b0};
      line[0] = tline;
      col[0]  = tcol;
      off[0]  = toff;
      len[0]  = a_len;
    end else begin
      tag[0]  = tag[2];
      line[0] = line[2];
      col[0]  = col[2];
      off[0]  = off[2];
      len[0]  = len[2];
    end

    tag[0].last = (n == 2'd1);
    tag[1].last = (n == 2'd2);
    tag[2].last = (n == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      line_cnt <= P'(1);
      col_cnt  <= P'(1);
      offset   <= '0;
      tline    <= P'(1);
      tcol     <= P'(1);
      toff     <= '0;
      tlen     <= '0;
    end else if (go) begin
      mode     <= mode_next;
      line_cnt <= line_cnt_next;
      col_cnt  <= col_cnt_next;
      offset   <= offset_next;
      tline    <= tline_next;
      tcol     <= tcol_next;
      toff     <= toff_next;
      tlen     <= tlen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && kw_we) begin
      kw[kw_wa] <= c;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/script_lexer_tokenizer.sv -----
// Top level of the streaming script lexer: input register, scanner and
// a four-entry result queue that drives the token port. Uses slt_pkg, slt_scan.
//
// Usage:
//   The input channel (in_valid, in_stall, source_byte, end_of_source) takes one
//   source byte per request, or an end-of-source request that flushes pending
//   tokens and produces EOF. The output channel (out_valid, out_stall and the
//   token fields) delivers token records in source order; last_of_run marks the
//   final token caused by one input request.
//   A request is registered on acceptance and scanned from that register once the
//   queue has room, when its zero to three tokens enter the result queue together;
//   the queue register then presents them to the output in order.
//   Throughput is one byte per cycle. The scan waits only while the queue lacks
//   room for the tokens of the registered request, so the input stalls when
//   tokens pile up faster than the receiver takes them, one token per cycle.
//   A stalled output holds its token. Reset empties the input register and the
//   queue and returns the scanner to line 1, column 1, offset 0.
`timescale 1ns / 1ps
`default_nettype none

module script_lexer_tokenizer
  import slt_pkg::*;
#(
  parameter int POSITION_BITS = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [7:0]               source_byte,
  input  wire logic                     end_of_source,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [5:0]                    token_kind,
  output logic [2:0]                    error_kind,
  output logic [POSITION_BITS-1:0]      start_line,
  output logic [POSITION_BITS-1:0]      start_column,
  output logic [OFFSET_BITS-1:0]        start_offset,
  output logic [POSITION_BITS-1:0]      lexeme_length,
  output logic                          last_of_run
);

  localparam int P  = POSITION_BITS;
  localparam int O  = OFFSET_BITS;
  localparam int CW = QCNT_BITS;

  typedef struct packed {
    tag_t          tag;
    logic [P-1:0]  line;
    logic [P-1:0]  col;
    logic [O-1:0]  off;
    logic [P-1:0]  len;
  } entry_t;

  logic           in_vld;
  logic [7:0]     in_byte;
  logic           in_end;
  logic           go;
  logic           room;
  logic           pop;

  logic [1:0]     n;
  tag_t           s_tag  [3];
  logic [P-1:0]   s_line [3];
  logic [P-1:0]   s_col  [3];
  logic [O-1:0]   s_off  [3];
  logic [P-1:0]   s_len  [3];

  entry_t         fresh  [3];
  entry_t         q      [QUEUE_DEPTH];
  entry_t         shf    [QUEUE_DEPTH];
  entry_t         q_next [QUEUE_DEPTH];
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  cnt_after;
  logic [CW-1:0]  j;

  slt_scan #(
    .POSITION_BITS (P),
    .OFFSET_BITS   (O)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .c         (in_byte),
    .last_item (in_end),
    .n         (n),
    .tag       (s_tag),
    .line      (s_line),
    .col       (s_col),
    .off       (s_off),
    .len       (s_len)
  );

  // Room is judged without the pop so that out_stall never reaches in_stall.
  assign room     = ({1'b0, cnt} + (CW+1)'(n)) <= (CW+1)'(QUEUE_DEPTH);
  assign go       = in_vld && room;
  assign in_stall = in_vld && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!in_stall) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte <= source_byte;
      in_end  <= end_of_source;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fresh[k] = '{tag: s_tag[k], line: s_line[k], col: s_col[k],
                   off: s_off[k], len: s_len[k]};
    end
  end

  assign out_valid = cnt != '0;
  assign pop       = out_valid && !out_stall;
  assign cnt_after = cnt - CW'(pop);
  assign cnt_next  = cnt_after + (go ? CW'(n) : CW'(0));

  // Shift the queue down on a pop, then append the new records behind it.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      shf[i] = pop ? q[i+1] : q[i];
    end
    shf[QUEUE_DEPTH-1] = q[QUEUE_DEPTH-1];
    j = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      j = CW'(i) - cnt_after;
      if (CW'(i) >= cnt_after && go && j < CW'(n)) begin
        q_next[i] = fresh[j[1:0]];
      end else begin
        q_next[i] = shf[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  assign token_kind    = q[0].tag.kind;
  assign error_kind    = q[0].tag.err;
  assign last_of_run   = q[0].tag.last;
  assign start_line    = q[0].line;
  assign start_column  = q[0].col;
  assign start_offset  = q[0].off;
  assign lexeme_length = q[0].len;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(QUEUE_DEPTH))
    else $error("result queue holds more entries than it has");

  a_empty_go: assert property (@(posedge clk) disable iff (rst)
    (in_vld && cnt == '0) |-> go)
    else $error("scan held back although the result queue is empty");

  a_run_whole: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> (cnt >= CW'(2)))
    else $error("token run split across queue fills");

endmodule

`default_nettype wire
